>>> sv/cftm_pkg.sv
// Package: shared types, constants and the coefficient functions of the THD meter.
`default_nettype none
package cftm_pkg;

   localparam int TAPS      = 281;
   localparam int COMB_MAX  = 256;
   localparam int BLOCK_MAX = 4096;
   localparam int ROM_LEN   = 281;
   localparam int ROM_HALF  = 141;

   localparam int TAP_W  = 9;   // bits to index the taps
   localparam int COMB_W = 8;   // bits to index the comb line
   localparam int CNT_W  = 12;  // sample counter bits

   localparam logic [1:0] CSR_GAIN_IN  = 2'd0;
   localparam logic [1:0] CSR_GAIN_FB  = 2'd1;
   localparam logic [1:0] CSR_DELAY    = 2'd2;
   localparam logic [1:0] CSR_BLOCK    = 2'd3;

   localparam logic [11:0] CODE_MAX = 12'd4095;
   localparam logic [23:0] RATIO_M  = 24'd16769025;  // 4095 squared

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COMB,
      ST_CLEAR,
      ST_MAC,
      ST_FLUSH,
      ST_ROUND,
      ST_ENERGY,
      ST_CHECK,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

   // Half tables of both filters, in units of 1e-8.
   function automatic int rom_total_half(input logic [7:0] j);
      case (j)
         8'd0: return 54709;     8'd1: return 85821;     8'd2: return 108468;
         8'd3: return 119782;    8'd4: return 118063;    8'd5: return 103018;
         8'd6: return 75842;     8'd7: return 39142;     8'd8: return -3305;
         8'd9: return -46940;    8'd10: return -86900;   8'd11: return -118560;
         8'd12: return -138062;  8'd13: return -142775;  8'd14: return -131636;
         8'd15: return -105329;  8'd16: return -66264;   8'd17: return -18373;
         8'd18: return 33281;    8'd19: return 83032;    8'd20: return 125230;
         8'd21: return 154871;   8'd22: return 168189;   8'd23: return 163116;
         8'd24: return 139577;   8'd25: return 99569;    8'd26: return 47004;
         8'd27: return -12659;   8'd28: return -72977;   8'd29: return -127208;
         8'd30: return -169062;  8'd31: return -193417;  8'd32: return -196939;
         8'd33: return -178513;  8'd34: return -139448;  8'd35: return -83409;
         8'd36: return -16091;   8'd37: return 55352;    8'd38: return 123057;
         8'd39: return 179310;   8'd40: return 217413;   8'd41: return 232473;
         8'd42: return 222008;   8'd43: return 186308;   8'd44: return 128499;
         8'd45: return 54292;    8'd46: return -28571;   8'd47: return -111112;
         8'd48: return -184076;  8'd49: return -238960;  8'd50: return -268987;
         8'd51: return -269927;  8'd52: return -240656;  8'd53: return -183390;
         8'd54: return -103553;  8'd55: return -9287;    8'd56: return 89368;
         8'd57: return 181523;   8'd58: return 256631;   8'd59: return 305672;
         8'd60: return 322221;   8'd61: return 303250;   8'd62: return 249594;
         8'd63: return 165996;   8'd64: return 60715;    8'd65: return -55263;
         8'd66: return -169352;  8'd67: return -268711;  8'd68: return -341668;
         8'd69: return -379060;  8'd70: return -375353;  8'd71: return -329390;
         8'd72: return -244691;  8'd73: return -129234;  8'd74: return 5256;
         8'd75: return 144476;   8'd76: return 273027;   8'd77: return 376092;
         8'd78: return 441103;   8'd79: return 459229;   8'd80: return 426509;
         8'd81: return 344492;   8'd82: return 220288;   8'd83: return 66011;
         8'd84: return -102357;  8'd85: return -266574;  8'd86: return -408069;
         8'd87: return -509985;  8'd88: return -559122;  8'd89: return -547564;
         8'd90: return -473792;  8'd91: return -343144;  8'd92: return -167537;
         8'd93: return 35534;    8'd94: return 244675;   8'd95: return 436761;
         8'd96: return 589403;   8'd97: return 683457;   8'd98: return 705295;
         8'd99: return 648588;   8'd100: return 515384;  8'd101: return 316327;
         8'd102: return 69960;   8'd103: return -198875; 8'd104: return -461399;
         8'd105: return -687811; 8'd106: return -850482; 8'd107: return -927093;
         8'd108: return -903384; 8'd109: return -775210; 8'd110: return -549635;
         8'd111: return -244920; 8'd112: return 110695;  8'd113: return 481311;
         8'd114: return 826659;  8'd115: return 1106056; 8'd116: return 1282667;
         8'd117: return 1327681; 8'd118: return 1223947; 8'd119: return 968721;
         8'd120: return 575162;  8'd121: return 72398;   8'd122: return -495946;
         8'd123: return -1074696; 8'd124: return -1601344; 8'd125: return -2011209;
         8'd126: return -2243114; 8'd127: return -2245072; 8'd128: return -1979480;
         8'd129: return -1427310; 8'd130: return -590914; 8'd131: return 504896;
         8'd132: return 1813613; 8'd133: return 3269670; 8'd134: return 4792745;
         8'd135: return 6293426; 8'd136: return 7679791; 8'd137: return 8864337;
         8'd138: return 9770707; 8'd139: return 10339625; 8'd140: return 10533549;
         default: return 0;
      endcase
   endfunction

   function automatic int rom_fund_half(input logic [7:0] j);
      case (j)
         8'd0: return 32125;     8'd1: return 28024;     8'd2: return 23664;
         8'd3: return 19048;     8'd4: return 14179;     8'd5: return 9063;
         8'd6: return 3704;      8'd7: return -1891;     8'd8: return -7714;
         8'd9: return -13757;    8'd10: return -20011;   8'd11: return -26466;
         8'd12: return -33111;   8'd13: return -39934;   8'd14: return -46923;
         8'd15: return -54063;   8'd16: return -61340;   8'd17: return -68739;
         8'd18: return -76242;   8'd19: return -83834;   8'd20: return -91496;
         8'd21: return -99210;   8'd22: return -106955;  8'd23: return -114712;
         8'd24: return -122460;  8'd25: return -130177;  8'd26: return -137842;
         8'd27: return -145430;  8'd28: return -152920;  8'd29: return -160287;
         8'd30: return -167506;  8'd31: return -174554;  8'd32: return -181405;
         8'd33: return -188034;  8'd34: return -194415;  8'd35: return -200523;
         8'd36: return -206331;  8'd37: return -211814;  8'd38: return -216945;
         8'd39: return -221699;  8'd40: return -226049;  8'd41: return -229971;
         8'd42: return -233438;  8'd43: return -236425;  8'd44: return -238907;
         8'd45: return -240861;  8'd46: return -242261;  8'd47: return -243085;
         8'd48: return -243309;  8'd49: return -242912;  8'd50: return -241871;
         8'd51: return -240168;  8'd52: return -237780;  8'd53: return -234690;
         8'd54: return -230880;  8'd55: return -226333;  8'd56: return -221033;
         8'd57: return -214965;  8'd58: return -208115;  8'd59: return -200473;
         8'd60: return -192026;  8'd61: return -182764;  8'd62: return -172681;
         8'd63: return -161768;  8'd64: return -150020;  8'd65: return -137434;
         8'd66: return -124006;  8'd67: return -109737;  8'd68: return -94627;
         8'd69: return -78678;   8'd70: return -61894;   8'd71: return -44280;
         8'd72: return -25844;   8'd73: return -6595;    8'd74: return 13457;
         8'd75: return 34299;    8'd76: return 55919;    8'd77: return 78299;
         8'd78: return 101425;   8'd79: return 125275;   8'd80: return 149831;
         8'd81: return 175070;   8'd82: return 200968;   8'd83: return 227501;
         8'd84: return 254642;   8'd85: return 282363;   8'd86: return 310634;
         8'd87: return 339425;   8'd88: return 368703;   8'd89: return 398435;
         8'd90: return 428585;   8'd91: return 459119;   8'd92: return 489998;
         8'd93: return 521185;   8'd94: return 552641;   8'd95: return 584325;
         8'd96: return 616196;   8'd97: return 648212;   8'd98: return 680332;
         8'd99: return 712511;   8'd100: return 744706;  8'd101: return 776873;
         8'd102: return 808967;  8'd103: return 840943;  8'd104: return 872756;
         8'd105: return 904360;  8'd106: return 935710;  8'd107: return 966761;
         8'd108: return 997467;  8'd109: return 1027783; 8'd110: return 1057664;
         8'd111: return 1087065; 8'd112: return 1115943; 8'd113: return 1144254;
         8'd114: return 1171955; 8'd115: return 1199004; 8'd116: return 1225359;
         8'd117: return 1250980; 8'd118: return 1275828; 8'd119: return 1299863;
         8'd120: return 1323049; 8'd121: return 1345349; 8'd122: return 1366728;
         8'd123: return 1387153; 8'd124: return 1406591; 8'd125: return 1425012;
         8'd126: return 1442387; 8'd127: return 1458687; 8'd128: return 1473887;
         8'd129: return 1487962; 8'd130: return 1500891; 8'd131: return 1512652;
         8'd132: return 1523226; 8'd133: return 1532597; 8'd134: return 1540749;
         8'd135: return 1547669; 8'd136: return 1553347; 8'd137: return 1557772;
         8'd138: return 1560938; 8'd139: return 1562840; 8'd140: return 1563474;
         default: return 0;
      endcase
   endfunction

   // Scale 1e-8 units to Q1.23, rounding half away from zero (elaboration only).
   function automatic logic signed [23:0] to_q23(input int v);
      longint m;
      longint q;
      m = (v < 0) ? -longint'(v) : longint'(v);
      q = (m * 64'sd8388608 + 64'sd50000000) / 64'sd100000000;
      return (v < 0) ? 24'(-q) : 24'(q);
   endfunction

   // Half tables already scaled to Q1.23, built once at elaboration.
   typedef logic [ROM_HALF-1:0][23:0] coef_tab_type;

   function automatic coef_tab_type build_total_tab();
      coef_tab_type t;
      for (int j = 0; j < ROM_HALF; j++) begin
         t[j] = to_q23(rom_total_half(8'(j)));
      end
      return t;
   endfunction

   function automatic coef_tab_type build_fund_tab();
      coef_tab_type t;
      for (int j = 0; j < ROM_HALF; j++) begin
         t[j] = to_q23(rom_fund_half(8'(j)));
      end
      return t;
   endfunction

   localparam coef_tab_type TOTAL_Q23 = build_total_tab();
   localparam coef_tab_type FUND_Q23  = build_fund_tab();

   // Full symmetric coefficient for tap j; zero beyond the table.
   function automatic logic signed [23:0] coeff_total(input logic [TAP_W-1:0] j);
      logic [TAP_W-1:0] k;
      k = (j < TAP_W'(ROM_HALF)) ? j : TAP_W'(ROM_LEN - 1) - j;
      if (j >= TAP_W'(ROM_LEN)) return '0;
      return TOTAL_Q23[k[7:0]];
   endfunction

   function automatic logic signed [23:0] coeff_fund(input logic [TAP_W-1:0] j);
      logic [TAP_W-1:0] k;
      k = (j < TAP_W'(ROM_HALF)) ? j : TAP_W'(ROM_LEN - 1) - j;
      if (j >= TAP_W'(ROM_LEN)) return '0;
      return FUND_Q23[k[7:0]];
   endfunction

   // Round-half-up shift right by s, then saturate to 24-bit signed.
   function automatic logic signed [23:0] round_sat(input logic signed [63:0] v,
                                                    input int s);
      logic signed [63:0] t;
      t = (v + (64'sd1 <<< (s - 1))) >>> s;
      if (t > 64'sd8388607) return 24'sh7FFFFF;
      if (t < -64'sd8388608) return 24'sh800000;
      return t[23:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/cftm_mac.sv
// Shared multiply-accumulate unit: one 24x24 product a cycle, registered before the add.
`default_nettype none
module cftm_mac (
   input  wire logic               clock,
   input  wire logic               clear,
   input  wire logic               enable,
   input  wire logic signed [23:0] op_a,
   input  wire logic signed [23:0] op_b,
   output logic signed [63:0]      acc
);

   logic signed [47:0] prod_ff;
   logic               pvld_ff;
   logic signed [63:0] acc_ff;

   // Product register, then accumulate.
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      pvld_ff <= enable & ~clear;
      if (clear) begin
         acc_ff <= '0;
      end else if (pvld_ff) begin
         acc_ff <= acc_ff + 64'(prod_ff);
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

>>> sv/cftm_root.sv
// Serial ratio divider followed by a serial integer square root.
`default_nettype none
module cftm_root (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [11:0]      root
);

   logic [63:0] r_ff;
   logic [23:0] q_ff;
   logic [4:0]  i_ff;
   logic        div_ff;
   logic        sq_ff;
   logic [31:0] v_ff;
   logic [31:0] res_ff;
   logic [31:0] bit_ff;
   logic        done_ff;

   logic [63:0] r1;
   logic [23:0] q1;
   logic [63:0] r2;
   logic [23:0] q2;

   // One divider bit: double the remainder, then add the numerator if m has a one.
   always_comb begin
      if (r_ff >= den - r_ff) begin
         r1 = r_ff - (den - r_ff);
         q1 = {q_ff[22:0], 1'b1};
      end else begin
         r1 = r_ff + r_ff;
         q1 = {q_ff[22:0], 1'b0};
      end
      r2 = r1;
      q2 = q1;
      if (cftm_pkg::RATIO_M[i_ff]) begin
         if (r1 >= den - num) begin
            r2 = r1 - (den - num);
            q2 = q1 + 24'd1;
         end else begin
            r2 = r1 + num;
         end
      end
   end

   // Divider then root sequence.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         div_ff <= 1'b0;
         sq_ff  <= 1'b0;
      end else if (start) begin
         div_ff <= 1'b1;
         r_ff   <= '0;
         q_ff   <= '0;
         i_ff   <= 5'd23;
      end else if (div_ff) begin
         r_ff <= r2;
         q_ff <= q2;
         i_ff <= i_ff - 5'd1;
         if (i_ff == 5'd0) begin
            div_ff <= 1'b0;
            sq_ff  <= 1'b1;
            v_ff   <= {8'd0, q2};
            res_ff <= '0;
            bit_ff <= 32'h4000_0000;
         end
      end else if (sq_ff) begin
         if (bit_ff == 32'd0) begin
            sq_ff   <= 1'b0;
            done_ff <= 1'b1;
         end else if (bit_ff > v_ff && res_ff == 32'd0) begin
            bit_ff <= bit_ff >> 2;
         end else begin
            if (v_ff >= res_ff + bit_ff) begin
               v_ff   <= v_ff - (res_ff + bit_ff);
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[11:0];

endmodule
`default_nettype wire

>>> sv/comb_fir_thd_meter_core.sv
// Top level: comb-filtered dual FIR THD meter with a shared MAC sequencer.
//
// Input channel req_: one unsigned 12-bit converter word per handshake
// (req_valid high, req_stall low). Result channel rsp_: one word per input,
// carrying the held THD code and a block-end flag. Configuration goes through
// a plain write port (csr_write, csr_index, csr_data); the user is to write it
// only while the block idles, as the block itself does not enforce this.
// Each word runs: the comb update, a history write, then two MAC passes over
// the 281 taps, the two filters taking turns on one multiplier, then energy
// update, block check and output. A word that closes a block, unless the
// energy check settles the code directly, adds a 24-step divider and 16
// square-root steps. req_stall is high from acceptance until the result word
// is taken.
//
// Reset (synchronous, active high) restores the register defaults and clears
// the energies, positions and code. The comb line and the shared history are
// cleared by a sweep after reset, during which req_stall stays high. A
// stalled result word is held and blocks the input until it goes.
`default_nettype none
module comb_fir_thd_meter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [11:0] req_adc_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_dac_code,
   output logic             rsp_block_end,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int TW = cftm_pkg::TAP_W;
   localparam int CW = cftm_pkg::COMB_W;

   // Configuration registers.
   logic [15:0] gain_in_ff;
   logic [15:0] gain_fb_ff;
   logic [8:0]  delay_ff;
   logic [12:0] blen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_in_ff <= 16'd11796;
         gain_fb_ff <= 16'd53084;
         delay_ff   <= 9'd200;
         blen_ff    <= 13'd1000;
      end else if (csr_write) begin
         unique case (csr_index)
            cftm_pkg::CSR_GAIN_IN: gain_in_ff <= csr_data;
            cftm_pkg::CSR_GAIN_FB: gain_fb_ff <= csr_data;
            cftm_pkg::CSR_DELAY:   delay_ff   <= csr_data[8:0];
            cftm_pkg::CSR_BLOCK:   blen_ff    <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // Memories: comb line and one shared history (both filters see the same data).
   logic signed [23:0] comb_mem [cftm_pkg::COMB_MAX];
   logic signed [23:0] hist_mem [cftm_pkg::TAPS];

   cftm_pkg::state_type state_ff, state_in;

   logic [TW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      cpos_ff, cpos_in;
   logic [TW-1:0]      hpos_ff, hpos_in;
   logic [11:0]        scnt_ff, scnt_in;
   logic [11:0]        code_ff, code_in;
   logic [63:0]        et_ff, et_in;
   logic [63:0]        e0_ff, e0_in;
   logic [11:0]        x_ff, x_in;
   logic signed [23:0] y_ff, y_in;
   logic               end_ff, end_in;
   logic               rv_ff, rv_in;
   logic               phase_ff, phase_in;
   logic signed [23:0] ft_ff, ft_in;
   logic signed [23:0] ff_ff, ff_in;

   logic signed [23:0] comb_rd_ff;
   logic signed [23:0] hist_rd_ff;
   logic               clr_mem;
   logic               comb_we;
   logic               hist_we;
   logic [TW-1:0]      hist_ra;
   logic [TW-1:0]      tap_idx;

   // Read and write ports.
   always_ff @(posedge clock) begin
      comb_rd_ff <= comb_mem[cpos_ff];
      hist_rd_ff <= hist_mem[hist_ra];
      if (clr_mem) begin
         if (cnt_ff < TW'(cftm_pkg::COMB_MAX)) begin
            comb_mem[cnt_ff[CW-1:0]] <= '0;
         end
         hist_mem[cnt_ff] <= '0;
      end else begin
         if (comb_we) begin
            comb_mem[cpos_ff] <= y_ff;
         end
         if (hist_we) begin
            hist_mem[hpos_ff] <= y_ff;
         end
      end
   end

   // History address for tap index: newest minus tap, wrapped.
   assign tap_idx = cnt_ff;
   assign hist_ra = (hpos_ff >= tap_idx) ? hpos_ff - tap_idx
                  : hpos_ff + TW'(cftm_pkg::TAPS) - tap_idx;

   // Shared MAC: two passes, total band then fundamental, share one multiplier.
   logic               mac_clr;
   logic               mac_en;
   logic signed [23:0] mac_a;
   logic signed [23:0] mac_b;
   logic signed [63:0] mac_acc;
   logic [TW-1:0]      coef_idx_ff;

   always_ff @(posedge clock) begin
      coef_idx_ff <= tap_idx;
   end

   assign mac_a = phase_ff ? cftm_pkg::coeff_fund(coef_idx_ff)
                           : cftm_pkg::coeff_total(coef_idx_ff);
   assign mac_b = hist_rd_ff;

   cftm_mac u_mac (
      .clock  (clock),
      .clear  (mac_clr),
      .enable (mac_en),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .acc    (mac_acc)
   );

   // Comb arithmetic: two narrow products, then round.
   logic signed [63:0] comb_sum;
   logic signed [23:0] xq;
   assign xq = 24'((25'(x_ff) - 25'sd2048) <<< 8);
   assign comb_sum = 64'($signed({1'b0, gain_in_ff}) * xq)
                   + 64'($signed({1'b0, gain_fb_ff}) * comb_rd_ff);

   // Energy update.
   logic [63:0] sq_t, sq_f;
   logic [64:0] sum_t, sum_f;
   assign sq_t  = 64'(ft_ff * ft_ff);
   assign sq_f  = 64'(ff_ff * ff_ff);
   assign sum_t = {1'b0, et_ff} + {1'b0, sq_t};
   assign sum_f = {1'b0, e0_ff} + {1'b0, sq_f};

   // Effective limits.
   logic [8:0]  dlen;
   logic [12:0] blen;
   assign dlen = (delay_ff == 9'd0) ? 9'd1
               : (delay_ff > 9'd256) ? 9'd256 : delay_ff;
   assign blen = (blen_ff == 13'd0) ? 13'd1
               : (blen_ff > 13'd4096) ? 13'd4096 : blen_ff;

   // Root unit.
   logic        root_start;
   logic        root_done;
   logic [11:0] root_val;

   cftm_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .num   (et_ff - e0_ff),
      .den   (e0_ff),
      .done  (root_done),
      .root  (root_val)
   );

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cpos_in    = cpos_ff;
      hpos_in    = hpos_ff;
      scnt_in    = scnt_ff;
      code_in    = code_ff;
      et_in      = et_ff;
      e0_in      = e0_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      end_in     = end_ff;
      rv_in      = rv_ff;
      phase_in   = phase_ff;
      ft_in      = ft_ff;
      ff_in      = ff_ff;
      clr_mem    = 1'b0;
      comb_we    = 1'b0;
      hist_we    = 1'b0;
      mac_clr    = 1'b0;
      mac_en     = 1'b0;
      root_start = 1'b0;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         cftm_pkg::ST_CLEAR: begin
            clr_mem = 1'b1;
            cnt_in  = cnt_ff + TW'(1);
            if (cnt_ff == TW'(cftm_pkg::TAPS - 1)) begin
               state_in = cftm_pkg::ST_IDLE;
            end
         end
         cftm_pkg::ST_IDLE: begin
            if (req_valid && !rv_ff) begin
               x_in     = req_adc_sample;
               state_in = cftm_pkg::ST_COMB;
               cnt_in   = '0;
            end
         end
         cftm_pkg::ST_COMB: begin
            // comb_rd_ff was read at cpos during the first comb cycle.
            if (cnt_ff == '0) begin
               cnt_in = TW'(1);
            end else begin
               y_in     = cftm_pkg::round_sat(comb_sum, 16);
               cnt_in   = '0;
               state_in = cftm_pkg::ST_FLUSH;
            end
         end
         cftm_pkg::ST_FLUSH: begin
            // Write comb and history, advance comb position, start first pass.
            comb_we  = 1'b1;
            hist_we  = 1'b1;
            cpos_in  = (9'(cpos_ff) + 9'd1 >= dlen) ? '0 : cpos_ff + CW'(1);
            mac_clr  = 1'b1;
            phase_in = 1'b0;
            cnt_in   = '0;
            state_in = cftm_pkg::ST_MAC;
         end
         cftm_pkg::ST_MAC: begin
            // Address cycle cnt feeds read, then coefficient and product.
            if (cnt_ff <= TW'(cftm_pkg::TAPS)) begin
               mac_en = (cnt_ff != '0);
               cnt_in = cnt_ff + TW'(1);
            end else begin
               mac_en = 1'b0;
               cnt_in = cnt_ff + TW'(1);
               if (cnt_ff == TW'(cftm_pkg::TAPS + 2)) begin
                  if (!phase_ff) begin
                     ft_in    = cftm_pkg::round_sat(mac_acc, 23);
                     phase_in = 1'b1;
                     mac_clr  = 1'b1;
                     cnt_in   = '0;
                  end else begin
                     ff_in    = cftm_pkg::round_sat(mac_acc, 23);
                     state_in = cftm_pkg::ST_ROUND;
                  end
               end
            end
         end
         cftm_pkg::ST_ROUND: begin
            hpos_in  = (hpos_ff + TW'(1) >= TW'(cftm_pkg::TAPS)) ? '0 : hpos_ff + TW'(1);
            et_in    = sum_t[64] ? '1 : sum_t[63:0];
            e0_in    = sum_f[64] ? '1 : sum_f[63:0];
            state_in = cftm_pkg::ST_CHECK;
         end
         cftm_pkg::ST_CHECK: begin
            if (13'(scnt_ff) + 13'd1 >= blen) begin
               scnt_in = '0;
               end_in  = 1'b1;
               if (et_ff == '1 || e0_ff == '1 || e0_ff == '0) begin
                  code_in  = cftm_pkg::CODE_MAX;
                  state_in = cftm_pkg::ST_OUT;
               end else if (et_ff < e0_ff) begin
                  code_in  = '0;
                  state_in = cftm_pkg::ST_OUT;
               end else if (et_ff - e0_ff >= e0_ff) begin
                  code_in  = cftm_pkg::CODE_MAX;
                  state_in = cftm_pkg::ST_OUT;
               end else begin
                  root_start = 1'b1;
                  state_in   = cftm_pkg::ST_SQRT;
               end
            end else begin
               scnt_in  = scnt_ff + 12'd1;
               end_in   = 1'b0;
               state_in = cftm_pkg::ST_OUT;
            end
         end
         cftm_pkg::ST_SQRT: begin
            if (root_done) begin
               code_in  = root_val;
               state_in = cftm_pkg::ST_OUT;
            end
         end
         cftm_pkg::ST_OUT: begin
            if (end_ff) begin
               et_in = '0;
               e0_in = '0;
            end
            rv_in    = 1'b1;
            state_in = cftm_pkg::ST_IDLE;
         end
         default: begin
            state_in = cftm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cftm_pkg::ST_CLEAR;
         cnt_ff   <= '0;
         cpos_ff  <= '0;
         hpos_ff  <= '0;
         scnt_ff  <= '0;
         code_ff  <= '0;
         et_ff    <= '0;
         e0_ff    <= '0;
         rv_ff    <= 1'b0;
         end_ff   <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cpos_ff  <= cpos_in;
         hpos_ff  <= hpos_in;
         scnt_ff  <= scnt_in;
         code_ff  <= code_in;
         et_ff    <= et_in;
         e0_ff    <= e0_in;
         rv_ff    <= rv_in;
         end_ff   <= end_in;
         phase_ff <= phase_in;
      end
      x_ff  <= x_in;
      y_ff  <= y_in;
      ft_ff <= ft_in;
      ff_ff <= ff_in;
   end

   assign req_stall     = (state_ff != cftm_pkg::ST_IDLE) || rv_ff;
   assign rsp_valid     = rv_ff;
   assign rsp_dac_code  = code_ff;
   assign rsp_block_end = end_ff;

   // Checks.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (rv_ff |-> req_stall))
      else $error("input taken while a result word waits");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall |=> rv_ff && $stable(code_ff)))
      else $error("stalled result changed");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (hpos_ff < TW'(cftm_pkg::TAPS)))
      else $error("history position out of range");
   a_root_seq: assert property (@(posedge clock) disable iff (reset)
      (root_done |-> state_ff == cftm_pkg::ST_SQRT))
      else $error("root finished outside its state");

endmodule
`default_nettype wire
